/* rtl/aabb_pkg.sv */
// Shared types and constants for the AABB pair contact tracker.
`default_nettype none

package aabb_pkg;

  // Contact event codes as reported on out_contact_event.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ENTER = 2'd1;
  localparam logic [1:0] EV_STAY  = 2'd2;
  localparam logic [1:0] EV_EXIT  = 2'd3;

  // Depth of the queue between the front and the back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // One classified pair as handed from the front to the back.
  typedef struct packed {
    logic [63:0] key;
    logic        overlap;
    logic        dying;
    logic        same_ids;
  } item_t;

endpackage

`default_nettype wire

/* rtl/aabb_front.sv */
// Front end: accepts a pair, runs the overlap test and builds the pair key.
`default_nettype none

module aabb_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                  start,
  input  wire logic                  q_full,
  input  wire logic [31:0]           in_left_id,
  input  wire logic [31:0]           in_right_id,
  input  wire logic [COORD_BITS-1:0] in_left_x,
  input  wire logic [COORD_BITS-1:0] in_left_y,
  input  wire logic [COORD_BITS-1:0] in_left_w,
  input  wire logic [COORD_BITS-1:0] in_left_h,
  input  wire logic [COORD_BITS-1:0] in_right_x,
  input  wire logic [COORD_BITS-1:0] in_right_y,
  input  wire logic [COORD_BITS-1:0] in_right_w,
  input  wire logic [COORD_BITS-1:0] in_right_h,
  input  wire logic                  in_pair_dying,
  output logic                       busy,
  output logic                       push,
  output aabb_pkg::item_t            item
);

  localparam int unsigned W = COORD_BITS;

  logic signed [W:0] dx, dy;
  logic [W-1:0]      adx, ady;
  logic [W:0]        sum_w, sum_h;
  logic              ov_x, ov_y;

  // The centre difference needs one extra bit; its magnitude fits in W bits.
  always_comb begin
    dx    = $signed({in_right_x[W-1], in_right_x}) - $signed({in_left_x[W-1], in_left_x});
    dy    = $signed({in_right_y[W-1], in_right_y}) - $signed({in_left_y[W-1], in_left_y});
    adx   = dx[W] ? W'(-dx) : dx[W-1:0];
    ady   = dy[W] ? W'(-dy) : dy[W-1:0];
    sum_w = {1'b0, in_left_w} + {1'b0, in_right_w};
    sum_h = {1'b0, in_left_h} + {1'b0, in_right_h};
    ov_x  = {adx, 1'b0} <= sum_w;
    ov_y  = {ady, 1'b0} <= sum_h;
  end

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    item.key      = {in_left_id, in_right_id};
    item.overlap  = ov_x && ov_y && (in_left_id != in_right_id);
    item.dying    = in_pair_dying;
    item.same_ids = (in_left_id == in_right_id);
  end

endmodule

`default_nettype wire

/* rtl/aabb_queue.sv */
// Short queue that decouples the front end from the table back end.
`default_nettype none

module aabb_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire aabb_pkg::item_t push_item,
  input  wire logic            pop,
  output aabb_pkg::item_t      pop_item,
  output logic                 empty,
  output logic                 full
);

  aabb_pkg::item_t                 slot_r [aabb_pkg::Q_DEPTH];
  logic [aabb_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [aabb_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [aabb_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == aabb_pkg::Q_CNT_W'(aabb_pkg::Q_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/aabb_back.sv */
// Back end: searches the contact table, inserts new pairs and issues events.
`default_nettype none

module aabb_back #(
  parameter int unsigned PAIR_SLOTS = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire aabb_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic [1:0]           out_contact_event,
  output logic                 out_boxes_overlap,
  output logic                 out_table_full
);

  localparam int unsigned CNTW = $clog2(PAIR_SLOTS + 1);
  localparam int unsigned IDXW = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  typedef struct packed {
    logic        touch;
    logic [63:0] key;
  } entry_t;

  entry_t          mem [PAIR_SLOTS];
  entry_t          mem_q;

  state_t          state_r, state_nxt;
  aabb_pkg::item_t cur_r, cur_nxt;
  logic [CNTW-1:0] used_r, used_nxt;
  logic [CNTW-1:0] scan_r, scan_nxt;
  logic [IDXW-1:0] rd_idx_r, rd_idx_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [IDXW-1:0] slot_r, slot_nxt;
  logic            touch_r, touch_nxt;
  logic            rd_en, hit, tbl_full, wr_en, touch_new;
  logic [1:0]      ev;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_ev_r, out_ev_nxt;
  logic            out_ov_r, out_ov_nxt;
  logic            out_full_r, out_full_nxt;

  assign hit      = rd_vld_r && (mem_q.key == cur_r.key);
  assign tbl_full = (used_r == CNTW'(PAIR_SLOTS));

  // Event decode for the slot that was found or just inserted.
  always_comb begin
    touch_new = cur_r.overlap && !cur_r.dying;
    if (cur_r.overlap && touch_r) begin
      ev = cur_r.dying ? aabb_pkg::EV_EXIT : aabb_pkg::EV_STAY;
    end else if (cur_r.overlap) begin
      ev = cur_r.dying ? aabb_pkg::EV_NONE : aabb_pkg::EV_ENTER;
    end else begin
      ev = touch_r ? aabb_pkg::EV_EXIT : aabb_pkg::EV_NONE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    used_nxt      = used_r;
    scan_nxt      = scan_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    slot_nxt      = slot_r;
    touch_nxt     = touch_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    q_pop         = 1'b0;
    out_valid_nxt = 1'b0;
    out_ev_nxt    = out_ev_r;
    out_ov_nxt    = out_ov_r;
    out_full_nxt  = out_full_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          if (q_item.same_ids) begin
            out_valid_nxt = 1'b1;
            out_ev_nxt    = aabb_pkg::EV_NONE;
            out_ov_nxt    = 1'b0;
            out_full_nxt  = 1'b0;
          end else begin
            scan_nxt  = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // One table read is issued per cycle; its registered data is compared in the next cycle.
        if (hit) begin
          slot_nxt  = rd_idx_r;
          touch_nxt = mem_q.touch;
          state_nxt = ST_UPD;
        end else if (scan_r == used_r) begin
          if (tbl_full) begin
            out_valid_nxt = 1'b1;
            out_ev_nxt    = aabb_pkg::EV_NONE;
            out_ov_nxt    = cur_r.overlap;
            out_full_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            slot_nxt  = used_r[IDXW-1:0];
            touch_nxt = 1'b0;
            used_nxt  = used_r + 1'b1;
            state_nxt = ST_UPD;
          end
        end else begin
          rd_en      = 1'b1;
          rd_idx_nxt = scan_r[IDXW-1:0];
          rd_vld_nxt = 1'b1;
          scan_nxt   = scan_r + 1'b1;
        end
      end
      ST_UPD: begin
        wr_en         = 1'b1;
        out_valid_nxt = 1'b1;
        out_ev_nxt    = ev;
        out_ov_nxt    = cur_r.overlap;
        out_full_nxt  = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    scan_r     <= scan_nxt;
    rd_idx_r   <= rd_idx_nxt;
    slot_r     <= slot_nxt;
    touch_r    <= touch_nxt;
    out_ev_r   <= out_ev_nxt;
    out_ov_r   <= out_ov_nxt;
    out_full_r <= out_full_nxt;
  end

  // Contact table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_r] <= '{touch: touch_new, key: cur_r.key};
    end
    if (rd_en) begin
      mem_q <= mem[scan_r[IDXW-1:0]];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_contact_event = out_ev_r;
  assign out_boxes_overlap = out_ov_r;
  assign out_table_full    = out_full_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNTW'(PAIR_SLOTS))
    else $error("fill count exceeds table size");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r)) |-> (used_r == $past(used_r) + 1'b1) && $past(state_r == ST_SCAN))
    else $error("fill count moved by other than one insertion");

  a_full_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_contact_event == aabb_pkg::EV_NONE) && tbl_full)
    else $error("table full result with an event or spare room");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_UPD) || $past(state_r == ST_SCAN) ||
                  $past(state_r == ST_IDLE && !q_empty))
    else $error("result strobe without a finished pair");

endmodule

`default_nettype wire

/* rtl/aabb_pair_contact_tracker_unit.sv */
// Top level of the AABB pair contact tracker.
// Results are registered in the back end and cannot be stalled; equal ids skip the table
// search. The pair rate is set by the linear key scan through the single-read-port contact
// table, one slot per cycle; the queue holds up to two pairs while the back end is busy.
// Synchronous reset clears fill count, queue and control; table contents need no clearing.
`default_nettype none

module aabb_pair_contact_tracker_unit #(
  parameter int unsigned PAIR_SLOTS = 256,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [31:0]           in_left_id,
  input  wire logic [31:0]           in_right_id,
  input  wire logic [COORD_BITS-1:0] in_left_x,
  input  wire logic [COORD_BITS-1:0] in_left_y,
  input  wire logic [COORD_BITS-1:0] in_left_w,
  input  wire logic [COORD_BITS-1:0] in_left_h,
  input  wire logic [COORD_BITS-1:0] in_right_x,
  input  wire logic [COORD_BITS-1:0] in_right_y,
  input  wire logic [COORD_BITS-1:0] in_right_w,
  input  wire logic [COORD_BITS-1:0] in_right_h,
  input  wire logic                  in_pair_dying,
  output logic                       out_valid,
  output logic [1:0]                 out_contact_event,
  output logic                       out_boxes_overlap,
  output logic                       out_table_full
);

  aabb_pkg::item_t push_item, pop_item;
  logic            push, pop, q_empty, q_full;

  aabb_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .start         (start),
    .q_full        (q_full),
    .in_left_id    (in_left_id),
    .in_right_id   (in_right_id),
    .in_left_x     (in_left_x),
    .in_left_y     (in_left_y),
    .in_left_w     (in_left_w),
    .in_left_h     (in_left_h),
    .in_right_x    (in_right_x),
    .in_right_y    (in_right_y),
    .in_right_w    (in_right_w),
    .in_right_h    (in_right_h),
    .in_pair_dying (in_pair_dying),
    .busy          (busy),
    .push          (push),
    .item          (push_item)
  );

  aabb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  aabb_back #(
    .PAIR_SLOTS (PAIR_SLOTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_item            (pop_item),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_contact_event (out_contact_event),
    .out_boxes_overlap (out_boxes_overlap),
    .out_table_full    (out_table_full)
  );

endmodule

`default_nettype wire
